### hw/rtl/tsu_pkg.sv
`timescale 1ns / 1ps
package tsu_pkg;

  localparam int unsigned LEXEME_MAX_DEF = 1024;
  localparam int unsigned NEST_MAX_DEF   = 15;
  localparam int unsigned LINE_BITS_DEF  = 16;

  localparam int unsigned NUM_KW = 15;

  localparam logic [30:0] INT_SAT = 31'h7fff_ffff;

  // token classes
  localparam logic [3:0] CLS_END   = 4'd0;
  localparam logic [3:0] CLS_OP    = 4'd1;
  localparam logic [3:0] CLS_KW    = 4'd2;
  localparam logic [3:0] CLS_ID    = 4'd3;
  localparam logic [3:0] CLS_INT   = 4'd4;
  localparam logic [3:0] CLS_REAL  = 4'd5;
  localparam logic [3:0] CLS_STR   = 4'd6;
  localparam logic [3:0] CLS_PUN   = 4'd7;
  localparam logic [3:0] CLS_LINE  = 4'd8;
  localparam logic [3:0] CLS_NEST  = 4'd9;
  localparam logic [3:0] CLS_BLOCK = 4'd10;
  localparam logic [3:0] CLS_ERR   = 4'd11;

  // operator codes
  localparam logic [3:0] OP_ASSIGN = 4'd0;
  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_SUB    = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_DIV    = 4'd4;
  localparam logic [3:0] OP_MOD    = 4'd5;
  localparam logic [3:0] OP_EQ     = 4'd6;
  localparam logic [3:0] OP_NE     = 4'd7;
  localparam logic [3:0] OP_INC    = 4'd8;
  localparam logic [3:0] OP_DEC    = 4'd9;
  localparam logic [3:0] OP_GT     = 4'd10;
  localparam logic [3:0] OP_LT     = 4'd11;
  localparam logic [3:0] OP_GE     = 4'd12;
  localparam logic [3:0] OP_LE     = 4'd13;

  // punctuation codes
  localparam logic [3:0] PUN_LBRACE = 4'd0;
  localparam logic [3:0] PUN_RBRACE = 4'd1;
  localparam logic [3:0] PUN_LBRACK = 4'd2;
  localparam logic [3:0] PUN_RBRACK = 4'd3;
  localparam logic [3:0] PUN_LPAREN = 4'd4;
  localparam logic [3:0] PUN_RPAREN = 4'd5;
  localparam logic [3:0] PUN_SEMI   = 4'd6;
  localparam logic [3:0] PUN_COMMA  = 4'd7;
  localparam logic [3:0] PUN_COLON  = 4'd8;
  localparam logic [3:0] PUN_DCOLON = 4'd9;
  localparam logic [3:0] PUN_DOT    = 4'd10;
  localparam logic [3:0] PUN_DDOT   = 4'd11;
  localparam logic [3:0] CODE_NONE  = 4'd0;

  typedef enum logic [4:0] {
    S_START, S_IDENT, S_LT, S_GT, S_EQ, S_BANG, S_PLUS, S_MINUS, S_SLASH,
    S_COLON, S_DOT, S_INT, S_REAL, S_STR, S_LINE, S_BLK, S_BLK_SLASH, S_BLK_STAR
  } scan_state_e;

  typedef struct packed {
    logic [3:0]  token_class;
    logic [3:0]  token_code;
    logic [9:0]  token_length;
    logic [30:0] int_value;
    logic [15:0] line_number;
    logic        last_of_run;
  } res_t;

  function automatic logic [63:0] kw_text(input logic [3:0] j);
    logic [63:0] t;
    case (j)
      4'd0:    t = 64'("if");
      4'd1:    t = 64'("else");
      4'd2:    t = 64'("while");
      4'd3:    t = 64'("for");
      4'd4:    t = 64'("function");
      4'd5:    t = 64'("return");
      4'd6:    t = 64'("break");
      4'd7:    t = 64'("continue");
      4'd8:    t = 64'("and");
      4'd9:    t = 64'("not");
      4'd10:   t = 64'("or");
      4'd11:   t = 64'("local");
      4'd12:   t = 64'("true");
      4'd13:   t = 64'("false");
      4'd14:   t = 64'("nil");
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] j);
    logic [3:0] l;
    case (j)
      4'd0, 4'd10:                 l = 4'd2;
      4'd3, 4'd8, 4'd9, 4'd14:     l = 4'd3;
      4'd1, 4'd12:                 l = 4'd4;
      4'd2, 4'd6, 4'd11, 4'd13:    l = 4'd5;
      4'd5:                        l = 4'd6;
      4'd4, 4'd7:                  l = 4'd8;
      default:                     l = 4'd0;
    endcase
    return l;
  endfunction

  // character at position p of keyword j, zero beyond its end
  function automatic logic [7:0] kw_char(input logic [3:0] j, input logic [2:0] p);
    logic [63:0] t;
    logic [3:0]  l;
    logic [3:0]  sh;
    t  = kw_text(j);
    l  = kw_len(j);
    sh = l - 4'd1 - {1'b0, p};
    if ({1'b0, p} >= l) return 8'd0;
    return t[sh[2:0]*8 +: 8];
  endfunction

endpackage

### hw/rtl/token_scanner_unit.sv
`timescale 1ns / 1ps
// channel | handshake           | payload
// in      | in_valid_i/ready_o  | ch_i, end_of_text_i
// out     | out_valid_o/ready_i | token_class_o, token_code_o, token_length_o,
//         |                     | int_value_o, line_number_o, last_of_run_o
// one character is scanned per cycle while in_ready_o is high; its results enter a
// four-entry result queue on the same edge and are offered from the next cycle
// ready is high while the queue has room for two results, so a run of
// single-result characters streams at one per cycle while out_ready_i stays high;
// a two-result character puts both of its results into the queue
// reset returns the scanner to its start state with the line count at one
module token_scanner_unit #(
  parameter int unsigned LEXEME_MAX = tsu_pkg::LEXEME_MAX_DEF,
  parameter int unsigned NEST_MAX   = tsu_pkg::NEST_MAX_DEF,
  parameter int unsigned LINE_BITS  = tsu_pkg::LINE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_class_o,
  output logic [3:0]  token_code_o,
  output logic [9:0]  token_length_o,
  output logic [30:0] int_value_o,
  output logic [15:0] line_number_o,
  output logic        last_of_run_o
);
  import tsu_pkg::*;

  logic       fire;
  logic [1:0] res_cnt;
  res_t       res0, res1, head;

  assign fire = in_valid_i && in_ready_o;

  tsu_core #(
    .LEXEME_MAX(LEXEME_MAX),
    .NEST_MAX  (NEST_MAX),
    .LINE_BITS (LINE_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .ch_i     (ch_i),
    .eot_i    (end_of_text_i),
    .res_cnt_o(res_cnt),
    .res0_o   (res0),
    .res1_o   (res1)
  );

  tsu_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(res_cnt),
    .push0_i   (res0),
    .push1_i   (res1),
    .space2_o  (in_ready_o),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .data_o    (head)
  );

  assign token_class_o  = head.token_class;
  assign token_code_o   = head.token_code;
  assign token_length_o = head.token_length;
  assign int_value_o    = head.int_value;
  assign line_number_o  = head.line_number;
  assign last_of_run_o  = head.last_of_run;
endmodule

### hw/rtl/tsu_fifo.sv
`timescale 1ns / 1ps
module tsu_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_cnt_i,
  input  tsu_pkg::res_t push0_i,
  input  tsu_pkg::res_t push1_i,
  output logic          space2_o,
  output logic          valid_o,
  input  logic          ready_i,
  output tsu_pkg::res_t data_o
);
  import tsu_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign valid_o  = cnt_q != 3'd0;
  assign data_o   = mem_q[rd_q];
  assign pop      = valid_o && ready_i;
  assign space2_o = cnt_q <= 3'd2;

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_q + 2'd1] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_cnt_i;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, push_cnt_i} - {2'b0, pop};
    end
  end
endmodule

### hw/rtl/tsu_core.sv
`timescale 1ns / 1ps
module tsu_core #(
  parameter int unsigned LEXEME_MAX = tsu_pkg::LEXEME_MAX_DEF,
  parameter int unsigned NEST_MAX   = tsu_pkg::NEST_MAX_DEF,
  parameter int unsigned LINE_BITS  = tsu_pkg::LINE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    ch_i,
  input  logic          eot_i,
  output logic [1:0]    res_cnt_o,
  output tsu_pkg::res_t res0_o,
  output tsu_pkg::res_t res1_o
);
  import tsu_pkg::*;

  localparam int unsigned LW = $clog2(LEXEME_MAX);
  localparam int unsigned DW = $clog2(NEST_MAX + 1);
  localparam logic [LW-1:0] LEN_LIM  = LW'(LEXEME_MAX - 1);
  localparam logic [DW-1:0] NEST_LIM = DW'(NEST_MAX);

  scan_state_e        st_q, st_d;
  logic [LW-1:0]      len_q, len_d;
  logic [30:0]        acc_q, acc_d;
  logic [DW-1:0]      dep_q, dep_d;
  logic               nest_q, nest_d;
  logic [NUM_KW-1:0]  mask_q, mask_d;
  logic [LINE_BITS-1:0] line_q;

  res_t       res [2];
  logic [1:0] n;
  logic       rescan;
  logic       ovf;
  logic       is_alpha, is_digit, is_space;
  logic [3:0] dig;
  logic [34:0] prod;
  logic        kw_hit;
  logic [3:0]  kw_idx;
  logic [15:0] ln;

  assign is_alpha = (ch_i inside {["a":"z"], ["A":"Z"]});
  assign is_digit = (ch_i inside {["0":"9"]});
  assign is_space = (ch_i inside {[8'd9:8'd13], " "});
  assign dig      = 4'(ch_i - 8'h30);
  assign ovf      = len_q >= LEN_LIM;
  assign prod     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 35'(dig);
  assign ln       = 16'(line_q);

  // whole-word keyword match
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int j = NUM_KW - 1; j >= 0; j--) begin
      if (mask_q[j] && (32'(len_q) == 32'(kw_len(4'(j))))) begin
        kw_hit = 1'b1;
        kw_idx = 4'(j);
      end
    end
  end

  function automatic res_t mk(input logic [3:0] c, input logic [3:0] k,
                              input logic [9:0] l, input logic [30:0] v,
                              input logic [15:0] lnum);
    res_t r;
    r.token_class  = c;
    r.token_code   = k;
    r.token_length = l;
    r.int_value    = v;
    r.line_number  = lnum;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  always_comb begin
    st_d   = st_q;
    len_d  = len_q;
    acc_d  = acc_q;
    dep_d  = dep_q;
    nest_d = nest_q;
    mask_d = mask_q;
    res[0] = '0;
    res[1] = '0;
    n      = '0;
    rescan = 1'b0;

    if (eot_i) begin
      case (st_q)
        S_IDENT: begin
          if (kw_hit) res[n[0]] = mk(CLS_KW, kw_idx, 10'(len_q), '0, ln);
          else        res[n[0]] = mk(CLS_ID, CODE_NONE, 10'(len_q), '0, ln);
          n = n + 2'd1;
        end
        S_LT:    begin res[n[0]] = mk(CLS_OP, OP_LT, 10'd1, '0, ln); n = n + 2'd1; end
        S_GT:    begin res[n[0]] = mk(CLS_OP, OP_GT, 10'd1, '0, ln); n = n + 2'd1; end
        S_EQ:    begin res[n[0]] = mk(CLS_OP, OP_ASSIGN, 10'd1, '0, ln); n = n + 2'd1; end
        S_BANG:  begin res[n[0]] = mk(CLS_ERR, CODE_NONE, 10'd1, '0, ln); n = n + 2'd1; end
        S_PLUS:  begin res[n[0]] = mk(CLS_OP, OP_ADD, 10'd1, '0, ln); n = n + 2'd1; end
        S_MINUS: begin res[n[0]] = mk(CLS_OP, OP_SUB, 10'd1, '0, ln); n = n + 2'd1; end
        S_SLASH: begin res[n[0]] = mk(CLS_OP, OP_DIV, 10'd1, '0, ln); n = n + 2'd1; end
        S_COLON: begin res[n[0]] = mk(CLS_PUN, PUN_COLON, 10'd1, '0, ln); n = n + 2'd1; end
        S_DOT:   begin res[n[0]] = mk(CLS_PUN, PUN_DOT, 10'd1, '0, ln); n = n + 2'd1; end
        S_INT: begin
          res[n[0]] = mk(CLS_INT, CODE_NONE, 10'(len_q), acc_q, ln);
          n = n + 2'd1;
        end
        S_REAL: begin
          res[n[0]] = mk(CLS_REAL, CODE_NONE, 10'(len_q), '0, ln);
          n = n + 2'd1;
        end
        S_LINE: begin
          res[n[0]] = mk(CLS_LINE, CODE_NONE, 10'(len_q), '0, ln);
          n = n + 2'd1;
        end
        S_STR, S_BLK, S_BLK_SLASH, S_BLK_STAR: begin
          res[n[0]] = mk(CLS_ERR, CODE_NONE, 10'(len_q), '0, ln);
          n = n + 2'd1;
        end
        default: ;
      endcase
      res[n[0]] = mk(CLS_END, CODE_NONE, 10'd0, '0, ln);
      n = n + 2'd1;
      st_d = S_START; len_d = '0; acc_d = '0; dep_d = '0; nest_d = 1'b0; mask_d = '0;
    end else begin
      case (st_q)
        S_IDENT: begin
          if (is_alpha || is_digit || ch_i == "_") begin
            if (ovf) begin
              res[n[0]] = mk(CLS_ERR, CODE_NONE, 10'(len_q), '0, ln);
              n = n + 2'd1;
              st_d = S_START; len_d = '0; mask_d = '0;
            end else begin
              len_d = len_q + 1'b1;
              for (int j = 0; j < NUM_KW; j++) begin
                mask_d[j] = mask_q[j] && (32'(len_q) < 32'(kw_len(4'(j))))
                            && (kw_char(4'(j), len_q[2:0]) == ch_i);
              end
            end
          end else begin
            if (kw_hit) res[n[0]] = mk(CLS_KW, kw_idx, 10'(len_q), '0, ln);
            else        res[n[0]] = mk(CLS_ID, CODE_NONE, 10'(len_q), '0, ln);
            n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_LT, S_GT, S_EQ, S_BANG, S_PLUS, S_MINUS, S_COLON, S_DOT: begin
          logic [7:0] sec;
          logic [3:0] pcls, pcode, scls, scode;
          sec = "="; pcls = CLS_OP; scls = CLS_OP; pcode = OP_LE; scode = OP_LT;
          case (st_q)
            S_GT:    begin pcode = OP_GE; scode = OP_GT; end
            S_EQ:    begin pcode = OP_EQ; scode = OP_ASSIGN; end
            S_BANG:  begin pcode = OP_NE; scls = CLS_ERR; scode = CODE_NONE; end
            S_PLUS:  begin sec = "+"; pcode = OP_INC; scode = OP_ADD; end
            S_MINUS: begin sec = "-"; pcode = OP_DEC; scode = OP_SUB; end
            S_COLON: begin
              sec = ":"; pcls = CLS_PUN; scls = CLS_PUN; pcode = PUN_DCOLON; scode = PUN_COLON;
            end
            S_DOT: begin
              sec = "."; pcls = CLS_PUN; scls = CLS_PUN; pcode = PUN_DDOT; scode = PUN_DOT;
            end
            default: ;
          endcase
          if (ch_i == sec) begin
            res[n[0]] = mk(pcls, pcode, 10'd2, '0, ln);
            n = n + 2'd1;
            st_d = S_START; len_d = '0;
          end else begin
            res[n[0]] = mk(scls, scode, 10'd1, '0, ln);
            n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_SLASH: begin
          if (ch_i == "*") begin
            len_d = LW'(2); dep_d = DW'(1); nest_d = 1'b0; st_d = S_BLK;
          end else if (ch_i == "/") begin
            len_d = LW'(2); st_d = S_LINE;
          end else begin
            res[n[0]] = mk(CLS_OP, OP_DIV, 10'd1, '0, ln);
            n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_INT, S_REAL: begin
          if (is_digit || (st_q == S_INT && ch_i == ".")) begin
            if (ovf) begin
              res[n[0]] = mk(CLS_ERR, CODE_NONE, 10'(len_q), '0, ln);
              n = n + 2'd1;
              st_d = S_START; len_d = '0; acc_d = '0;
            end else begin
              len_d = len_q + 1'b1;
              if (!is_digit) st_d = S_REAL;
              else if (st_q == S_INT) acc_d = (prod > {4'b0, INT_SAT}) ? INT_SAT : prod[30:0];
            end
          end else begin
            if (st_q == S_INT) res[n[0]] = mk(CLS_INT, CODE_NONE, 10'(len_q), acc_q, ln);
            else               res[n[0]] = mk(CLS_REAL, CODE_NONE, 10'(len_q), '0, ln);
            n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        S_STR: begin
          if (is_alpha || is_digit || is_space || ch_i == "\"") begin
            if (ovf) begin
              res[n[0]] = mk(CLS_ERR, CODE_NONE, 10'(len_q), '0, ln);
              n = n + 2'd1;
              st_d = S_START; len_d = '0;
            end else if (ch_i == "\"") begin
              res[n[0]] = mk(CLS_STR, CODE_NONE, 10'({1'b0, len_q} + 1'b1), '0, ln);
              n = n + 2'd1;
              st_d = S_START; len_d = '0;
            end else begin
              len_d = len_q + 1'b1;
            end
          end else begin
            res[n[0]] = mk(CLS_ERR, CODE_NONE, 10'({1'b0, len_q} + 1'b1), '0, ln);
            n = n + 2'd1;
            st_d = S_START; len_d = '0;
          end
        end
        S_LINE: begin
          if (ch_i == 8'h0a || ovf) begin
            res[n[0]] = mk((ch_i == 8'h0a) ? CLS_LINE : CLS_ERR, CODE_NONE,
                           10'(len_q), '0, ln);
            n = n + 2'd1;
            st_d = S_START; len_d = '0;
          end else begin
            len_d = len_q + 1'b1;
          end
        end
        S_BLK, S_BLK_SLASH, S_BLK_STAR: begin
          if (ovf) begin
            res[n[0]] = mk(CLS_ERR, CODE_NONE, 10'(len_q), '0, ln);
            n = n + 2'd1;
            st_d = S_START; len_d = '0; dep_d = '0; nest_d = 1'b0;
          end else begin
            len_d = len_q + 1'b1;
            case (st_q)
              S_BLK: begin
                if (ch_i == "/") st_d = S_BLK_SLASH;
                else if (ch_i == "*") st_d = S_BLK_STAR;
              end
              S_BLK_SLASH: begin
                if (ch_i == "*") begin
                  if (dep_q >= NEST_LIM) begin
                    res[n[0]] = mk(CLS_ERR, CODE_NONE, 10'({1'b0, len_q} + 1'b1), '0, ln);
                    n = n + 2'd1;
                    st_d = S_START; len_d = '0; dep_d = '0; nest_d = 1'b0;
                  end else begin
                    dep_d = dep_q + 1'b1; nest_d = 1'b1; st_d = S_BLK;
                  end
                end else if (ch_i != "/") begin
                  st_d = S_BLK;
                end
              end
              default: begin
                if (ch_i == "/") begin
                  // outermost close ends the comment
                  if (dep_q <= DW'(1)) begin
                    res[n[0]] = mk(nest_q ? CLS_NEST : CLS_BLOCK, CODE_NONE,
                                   10'({1'b0, len_q} + 1'b1), '0, ln);
                    n = n + 2'd1;
                    st_d = S_START; len_d = '0; dep_d = '0; nest_d = 1'b0;
                  end else begin
                    dep_d = dep_q - 1'b1; st_d = S_BLK;
                  end
                end else if (ch_i != "*") begin
                  st_d = S_BLK;
                end
              end
            endcase
          end
        end
        default: rescan = 1'b1;
      endcase

      if (rescan) begin
        st_d = S_START; len_d = '0; acc_d = '0; dep_d = '0; nest_d = 1'b0; mask_d = '0;
        if (!is_space) begin
          len_d = LW'(1);
          if (is_alpha) begin
            st_d = S_IDENT;
            for (int j = 0; j < NUM_KW; j++) mask_d[j] = kw_char(4'(j), 3'd0) == ch_i;
          end else if (is_digit) begin
            st_d  = S_INT;
            acc_d = 31'(dig);
          end else begin
            case (ch_i)
              "<":  st_d = S_LT;
              ">":  st_d = S_GT;
              "=":  st_d = S_EQ;
              "!":  st_d = S_BANG;
              "+":  st_d = S_PLUS;
              "-":  st_d = S_MINUS;
              "/":  st_d = S_SLASH;
              ":":  st_d = S_COLON;
              ".":  st_d = S_DOT;
              "\"": st_d = S_STR;
              "*", "%": begin
                res[n[0]] = mk(CLS_OP, (ch_i == "*") ? OP_MUL : OP_MOD, 10'd1, '0, ln);
                n = n + 2'd1;
                len_d = '0;
              end
              "{", "}", "[", "]", "(", ")", ";", ",": begin
                logic [3:0] pc;
                case (ch_i)
                  "{":     pc = PUN_LBRACE;
                  "}":     pc = PUN_RBRACE;
                  "[":     pc = PUN_LBRACK;
                  "]":     pc = PUN_RBRACK;
                  "(":     pc = PUN_LPAREN;
                  ")":     pc = PUN_RPAREN;
                  ";":     pc = PUN_SEMI;
                  default: pc = PUN_COMMA;
                endcase
                res[n[0]] = mk(CLS_PUN, pc, 10'd1, '0, ln);
                n = n + 2'd1;
                len_d = '0;
              end
              default: begin
                res[n[0]] = mk(CLS_ERR, CODE_NONE, 10'd1, '0, ln);
                n = n + 2'd1;
                len_d = '0;
              end
            endcase
          end
        end
      end
    end

    if (n == 2'd1) res[0].last_of_run = 1'b1;
    if (n == 2'd2) res[1].last_of_run = 1'b1;
  end

  assign res_cnt_o = fire_i ? n : 2'd0;
  assign res0_o    = res[0];
  assign res1_o    = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_START;
      len_q  <= '0;
      acc_q  <= '0;
      dep_q  <= '0;
      nest_q <= 1'b0;
      mask_q <= '0;
      line_q <= LINE_BITS'(1);
    end else if (fire_i) begin
      st_q   <= st_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      dep_q  <= dep_d;
      nest_q <= nest_d;
      mask_q <= mask_d;
      if (!eot_i && ch_i == 8'h0a) line_q <= line_q + 1'b1;
    end
  end
endmodule

### tb/sv/token_scanner_unit_tb.sv
`timescale 1ns / 1ps
module token_scanner_unit_tb;
  import tsu_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [3:0] KW_IF      = 4'd0;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    logic [3:0] cls;
    logic [3:0] code;
    logic [9:0] len;
  } char_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  ch_i = 8'd0;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  token_class_o;
  logic [3:0]  token_code_o;
  logic [9:0]  token_length_o;
  logic [30:0] int_value_o;
  logic [15:0] line_number_o;
  logic        last_of_run_o;

  token_scanner_unit dut (.*);

  char_item_t  char_q[$];
  res_t        token_q[$];
  res_t        step_toks[$];
  int          errors = 0;
  int unsigned cycle = 0;
  int unsigned quiet = 0;
  logic        hold_off = 1'b0;
  string       kw_names[15] = '{"if", "else", "while", "for", "function", "return", "break",
                                "continue", "and", "not", "or", "local", "true", "false", "nil"};
  logic [63:0] kw_bits[15];

  // scanner shadow state
  scan_state_e sc_state;
  int          sc_len;
  longint      sc_acc;
  logic [15:0] sc_line;
  int          sc_depth;
  logic        sc_nested;
  logic [63:0] sc_word;

  initial forever #5 clk_i = ~clk_i;

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void add_tok(logic [3:0] cls, logic [3:0] code, int len, longint val);
    res_t r;
    if (step_toks.size() >= 2) return;
    r.token_class  = cls;
    r.token_code   = code;
    r.token_length = len[9:0];
    r.int_value    = val[30:0];
    r.line_number  = sc_line;
    r.last_of_run  = 1'b0;
    step_toks.push_back(r);
  endfunction

  function automatic void restart();
    sc_state  = S_START;
    sc_len    = 0;
    sc_acc    = 0;
    sc_depth  = 0;
    sc_nested = 1'b0;
    sc_word   = '0;
  endfunction

  function automatic bit grow();
    if (sc_len >= LEXEME_MAX_DEF - 1) begin
      add_tok(CLS_ERR, CODE_NONE, sc_len, 0);
      restart();
      return 1'b0;
    end
    sc_len++;
    return 1'b1;
  endfunction

  function automatic void word_tok();
    if (sc_len <= 8) begin
      for (int j = 0; j < 15; j++)
        if (kw_bits[j] == sc_word) begin
          add_tok(CLS_KW, 4'(j), sc_len, 0);
          return;
        end
    end
    add_tok(CLS_ID, CODE_NONE, sc_len, 0);
  endfunction

  function automatic void begin_tok(logic [7:0] c);
    restart();
    if (is_space(c)) return;
    sc_len = 1;
    if (is_alpha(c)) begin
      sc_state = S_IDENT;
      sc_word  = {56'd0, c};
      return;
    end
    if (is_digit(c)) begin
      sc_state = S_INT;
      sc_acc   = c - "0";
      return;
    end
    case (c)
      "<": sc_state = S_LT;
      ">": sc_state = S_GT;
      "=": sc_state = S_EQ;
      "!": sc_state = S_BANG;
      "+": sc_state = S_PLUS;
      "-": sc_state = S_MINUS;
      "/": sc_state = S_SLASH;
      ":": sc_state = S_COLON;
      ".": sc_state = S_DOT;
      "\"": sc_state = S_STR;
      "*": begin add_tok(CLS_OP, OP_MUL, 1, 0); restart(); end
      "%": begin add_tok(CLS_OP, OP_MOD, 1, 0); restart(); end
      "{": begin add_tok(CLS_PUN, PUN_LBRACE, 1, 0); restart(); end
      "}": begin add_tok(CLS_PUN, PUN_RBRACE, 1, 0); restart(); end
      "[": begin add_tok(CLS_PUN, PUN_LBRACK, 1, 0); restart(); end
      "]": begin add_tok(CLS_PUN, PUN_RBRACK, 1, 0); restart(); end
      "(": begin add_tok(CLS_PUN, PUN_LPAREN, 1, 0); restart(); end
      ")": begin add_tok(CLS_PUN, PUN_RPAREN, 1, 0); restart(); end
      ";": begin add_tok(CLS_PUN, PUN_SEMI, 1, 0); restart(); end
      ",": begin add_tok(CLS_PUN, PUN_COMMA, 1, 0); restart(); end
      default: begin add_tok(CLS_ERR, CODE_NONE, 1, 0); restart(); end
    endcase
  endfunction

  function automatic void pair_tok(logic [7:0] c, logic [7:0] second, logic [3:0] pcls,
                                   logic [3:0] pcode, logic [3:0] scls, logic [3:0] scode);
    if (c == second) begin
      add_tok(pcls, pcode, 2, 0);
      restart();
      return;
    end
    add_tok(scls, scode, 1, 0);
    begin_tok(c);
  endfunction

  function automatic void flush_tok();
    case (sc_state)
      S_IDENT:   word_tok();
      S_LT:      add_tok(CLS_OP, OP_LT, 1, 0);
      S_GT:      add_tok(CLS_OP, OP_GT, 1, 0);
      S_EQ:      add_tok(CLS_OP, OP_ASSIGN, 1, 0);
      S_BANG:    add_tok(CLS_ERR, CODE_NONE, 1, 0);
      S_PLUS:    add_tok(CLS_OP, OP_ADD, 1, 0);
      S_MINUS:   add_tok(CLS_OP, OP_SUB, 1, 0);
      S_SLASH:   add_tok(CLS_OP, OP_DIV, 1, 0);
      S_COLON:   add_tok(CLS_PUN, PUN_COLON, 1, 0);
      S_DOT:     add_tok(CLS_PUN, PUN_DOT, 1, 0);
      S_INT:     add_tok(CLS_INT, CODE_NONE, sc_len, sc_acc);
      S_REAL:    add_tok(CLS_REAL, CODE_NONE, sc_len, 0);
      S_LINE:    add_tok(CLS_LINE, CODE_NONE, sc_len, 0);
      S_STR, S_BLK, S_BLK_SLASH, S_BLK_STAR: add_tok(CLS_ERR, CODE_NONE, sc_len, 0);
      default: ;
    endcase
    restart();
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    case (sc_state)
      S_IDENT:
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          if (grow()) sc_word = {sc_word[55:0], c};
        end else begin
          word_tok();
          begin_tok(c);
        end
      S_LT:    pair_tok(c, "=", CLS_OP, OP_LE, CLS_OP, OP_LT);
      S_GT:    pair_tok(c, "=", CLS_OP, OP_GE, CLS_OP, OP_GT);
      S_EQ:    pair_tok(c, "=", CLS_OP, OP_EQ, CLS_OP, OP_ASSIGN);
      S_BANG:  pair_tok(c, "=", CLS_OP, OP_NE, CLS_ERR, CODE_NONE);
      S_PLUS:  pair_tok(c, "+", CLS_OP, OP_INC, CLS_OP, OP_ADD);
      S_MINUS: pair_tok(c, "-", CLS_OP, OP_DEC, CLS_OP, OP_SUB);
      S_COLON: pair_tok(c, ":", CLS_PUN, PUN_DCOLON, CLS_PUN, PUN_COLON);
      S_DOT:   pair_tok(c, ".", CLS_PUN, PUN_DDOT, CLS_PUN, PUN_DOT);
      S_SLASH:
        if (c == "*") begin
          sc_len = 2; sc_depth = 1; sc_nested = 1'b0; sc_state = S_BLK;
        end else if (c == "/") begin
          sc_len = 2; sc_state = S_LINE;
        end else begin
          add_tok(CLS_OP, OP_DIV, 1, 0);
          begin_tok(c);
        end
      S_INT:
        if (is_digit(c)) begin
          if (grow()) begin
            sc_acc = sc_acc * 10 + (c - "0");
            if (sc_acc > INT_SAT) sc_acc = INT_SAT;
          end
        end else if (c == ".") begin
          if (grow()) sc_state = S_REAL;
        end else begin
          add_tok(CLS_INT, CODE_NONE, sc_len, sc_acc);
          begin_tok(c);
        end
      S_REAL:
        if (is_digit(c)) void'(grow());
        else begin
          add_tok(CLS_REAL, CODE_NONE, sc_len, 0);
          begin_tok(c);
        end
      S_STR:
        if (is_alpha(c) || is_digit(c) || is_space(c)) void'(grow());
        else if (c == "\"") begin
          if (grow()) begin add_tok(CLS_STR, CODE_NONE, sc_len, 0); restart(); end
        end else begin
          add_tok(CLS_ERR, CODE_NONE, sc_len + 1, 0);
          restart();
        end
      S_LINE:
        if (c == 8'd10) begin
          add_tok(CLS_LINE, CODE_NONE, sc_len, 0);
          restart();
        end else void'(grow());
      S_BLK:
        if (grow()) begin
          if (c == "/") sc_state = S_BLK_SLASH;
          else if (c == "*") sc_state = S_BLK_STAR;
        end
      S_BLK_SLASH:
        if (grow()) begin
          if (c == "*") begin
            if (sc_depth >= NEST_MAX_DEF) begin
              add_tok(CLS_ERR, CODE_NONE, sc_len, 0);
              restart();
            end else begin
              sc_depth++; sc_nested = 1'b1; sc_state = S_BLK;
            end
          end else if (c != "/") sc_state = S_BLK;
        end
      S_BLK_STAR:
        if (grow()) begin
          if (c == "/") begin
            if (sc_depth > 0) sc_depth--;
            if (sc_depth == 0) begin
              add_tok(sc_nested ? CLS_NEST : CLS_BLOCK, CODE_NONE, sc_len, 0);
              restart();
            end else sc_state = S_BLK;
          end else if (c != "*") sc_state = S_BLK;
        end
      default: begin_tok(c);
    endcase
  endfunction

  function automatic void predict_tokens(char_item_t it);
    step_toks.delete();
    if (it.eot) begin
      flush_tok();
      add_tok(CLS_END, CODE_NONE, 0, 0);
    end else begin
      scan_byte(it.ch);
      if (it.ch == 8'd10) sc_line++;
    end
    if (step_toks.size() > 0) begin
      step_toks[step_toks.size()-1].last_of_run = 1'b1;
      if (it.typed) begin
        step_toks[0].token_class  = it.cls;
        step_toks[0].token_code   = it.code;
        step_toks[0].token_length = it.len;
      end
    end
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endfunction

  // stimulus building
  function automatic void row(logic [7:0] c, logic e, logic k, logic [3:0] cls,
                              logic [3:0] code, logic [9:0] len);
    char_item_t it;
    it.ch = c; it.eot = e; it.typed = k; it.cls = cls; it.code = code; it.len = len;
    char_q.push_back(it);
  endfunction

  function automatic void put(logic [7:0] c);
    row(c, 1'b0, 1'b0, CLS_END, CODE_NONE, '0);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(3))
      0: return 8'("a" + $urandom_range(25));
      1: return 8'("A" + $urandom_range(25));
      2: return 8'("0" + $urandom_range(9));
      default: return "_";
    endcase
  endfunction

  function automatic void rand_token();
    string ops[15] = '{"=", "+", "-", "*", "/", "%", "==", "!=", "++", "--",
                       ">", "<", ">=", "<=", "!"};
    string puns[12] = '{"{", "}", "[", "]", "(", ")", ";", ",", ":", "::", ".", ".."};
    string blk_chars = "ab /*\n";
    int n;
    case ($urandom_range(11))
      0, 1: put_text(kw_names[$urandom_range(14)]);
      2: begin
        put($urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25)));
        n = $urandom_range(11);
        repeat (n) put(rand_alnum());
      end
      3: repeat ($urandom_range(1, 12)) put(8'("0" + $urandom_range(9)));
      4: begin
        repeat ($urandom_range(1, 4)) put(8'("0" + $urandom_range(9)));
        put(".");
        repeat ($urandom_range(0, 4)) put(8'("0" + $urandom_range(9)));
      end
      5: begin
        put("\"");
        repeat ($urandom_range(0, 8))
          put($urandom_range(4) == 0 ? 8'(" ") : rand_alnum());
        put($urandom_range(9) == 0 ? 8'($urandom_range(255)) : 8'("\""));
      end
      6: put_text(ops[$urandom_range(14)]);
      7: put_text(puns[$urandom_range(11)]);
      8: begin
        put_text("//");
        repeat ($urandom_range(0, 10)) put(8'($urandom_range(32, 126)));
        put(8'd10);
      end
      9: begin
        put_text("/*");
        repeat ($urandom_range(0, 20)) put(blk_chars[$urandom_range(blk_chars.len() - 1)]);
        repeat ($urandom_range(1, 3)) put_text("*/");
      end
      10: put(8'($urandom_range(255)));
      default: row(8'($urandom_range(255)), 1'b1, 1'b0, CLS_END, CODE_NONE, '0);
    endcase
    case ($urandom_range(5))
      0, 1: put(" ");
      2: put(8'd10);
      3: put(8'd9);
      default: ;
    endcase
  endfunction

  function automatic void build_stimulus();
    row("*", 1'b0, 1'b1, CLS_OP, OP_MUL, 10'd1);
    row("%", 1'b0, 1'b1, CLS_OP, OP_MOD, 10'd1);
    row("{", 1'b0, 1'b1, CLS_PUN, PUN_LBRACE, 10'd1);
    row(",", 1'b0, 1'b1, CLS_PUN, PUN_COMMA, 10'd1);
    row(8'h00, 1'b0, 1'b1, CLS_ERR, CODE_NONE, 10'd1);
    row(8'hff, 1'b0, 1'b1, CLS_ERR, CODE_NONE, 10'd1);
    row("_", 1'b0, 1'b1, CLS_ERR, CODE_NONE, 10'd1);
    put("!");
    row("x", 1'b0, 1'b1, CLS_ERR, CODE_NONE, 10'd1);
    put("!");
    row("=", 1'b0, 1'b1, CLS_OP, OP_NE, 10'd2);
    put(">");
    row("=", 1'b0, 1'b1, CLS_OP, OP_GE, 10'd2);
    put("i");
    put("f");
    row(" ", 1'b0, 1'b1, CLS_KW, KW_IF, 10'd2);
    put(".");
    row(".", 1'b0, 1'b1, CLS_PUN, PUN_DDOT, 10'd2);
    put(":");
    row(":", 1'b0, 1'b1, CLS_PUN, PUN_DCOLON, 10'd2);
    put("\"");
    put("a");
    row(8'h55, 1'b1, 1'b1, CLS_ERR, CODE_NONE, 10'd2);
    while (char_q.size() < 700) rand_token();
    row(8'h00, 1'b1, 1'b0, CLS_END, CODE_NONE, '0);
    // lexeme overflow in a line comment
    put_text("//");
    repeat (1030) put("z");
    put(8'd10);
    // nesting beyond the limit
    repeat (NEST_MAX_DEF + 1) put_text("/*");
    put(" ");
    // integer saturation
    put_text("99999999999999 ");
    put_text("nil");
    row(8'h00, 1'b1, 1'b0, CLS_END, CODE_NONE, '0);
    while (char_q.size() < 1890) rand_token();
    row(8'h00, 1'b1, 1'b0, CLS_END, CODE_NONE, '0);
  endfunction

  function automatic bit calm();
    return cycle >= 300 && cycle < 900;
  endfunction

  // sender
  always @(posedge clk_i) begin
    bit fire;
    fire = in_valid_i && in_ready_o;
    if (fire) predict_tokens(char_q.pop_front());
    if (in_valid_i && !fire) begin
      // payload held until transfer
    end else if (rst_ni && char_q.size() > 0 && (calm() || $urandom_range(99) >= 30)) begin
      in_valid_i    <= 1'b1;
      ch_i          <= char_q[0].ch;
      end_of_text_i <= char_q[0].eot;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // receiver
  always @(posedge clk_i) begin
    res_t want;
    if (out_valid_o && out_ready_i) begin
      if (token_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected token expected none actual class %0d", $time, token_class_o);
      end else begin
        want = token_q.pop_front();
        check_field("token_class", want.token_class, token_class_o);
        check_field("token_code", want.token_code, token_code_o);
        check_field("token_length", want.token_length, token_length_o);
        check_field("int_value", want.int_value, int_value_o);
        check_field("line_number", want.line_number, line_number_o);
        check_field("last_of_run", want.last_of_run, last_of_run_o);
      end
    end
    out_ready_i <= rst_ni && !hold_off && (calm() || $urandom_range(99) >= 30);
  end

  // long receiver stall so the result queue fills and input stalls
  initial begin
    while (cycle < 1500) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int j = 0; j < 15; j++) begin
      kw_bits[j] = '0;
      for (int i = 0; i < kw_names[j].len(); i++)
        kw_bits[j] = {kw_bits[j][55:0], kw_names[j][i]};
    end
    restart();
    sc_line = 16'd1;
    build_stimulus();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (char_q.size() > 0 || token_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
